@@ rtl/rsi_pkg.sv @@
// Shared types and constants for the ray-sphere intersection pipeline.
// No dependencies; used by every module of the block.
package rsi_pkg;

   localparam int POS_W   = 32;
   localparam int DIR_W   = 18;
   localparam int RAD_W   = 31;
   localparam int DIST_W  = 37;
   localparam int DIR_FRAC = 16;
   localparam int L_W     = POS_W + 1;            // centre minus origin
   localparam int PROD_W  = L_W + DIR_W;          // one term of the dot product
   localparam int DOT_W   = PROD_W + 2;           // sum of three terms
   localparam int TCA_W   = 36;                   // non-negative dot over 2^16
   localparam int SQ_W    = 2 * L_W;              // one squared component
   localparam int LL_W    = SQ_W + 2;             // sum of three squares
   localparam int R2_W    = 2 * RAD_W;
   localparam int TCA2_W  = 2 * TCA_W;
   localparam int LIM_W   = TCA2_W + 1;
   localparam int ROOT_W  = 38;                   // root bits, top bit 37
   localparam int SQW     = 2 * ROOT_W;           // working width of the root unit
   localparam int IN_W    = 280;
   localparam int OUT_W   = 40;

   // Word handed from the geometry stages to the root unit.
   typedef struct packed {
      logic              vld;
      logic              hit;
      logic [TCA_W-1:0]  tca;
      logic [LIM_W-1:0]  rem;
   } geo_word_type;

endpackage

@@ rtl/rsi_geometry.sv @@
// Geometry stages: L = C - O, dot product, squares and the miss tests.
// Depends on rsi_pkg.
module rsi_geometry
   import rsi_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_vld,
   input  logic signed [POS_W-1:0]  origin_x,
   input  logic signed [POS_W-1:0]  origin_y,
   input  logic signed [POS_W-1:0]  origin_z,
   input  logic signed [DIR_W-1:0]  dir_x,
   input  logic signed [DIR_W-1:0]  dir_y,
   input  logic signed [DIR_W-1:0]  dir_z,
   input  logic signed [POS_W-1:0]  center_x,
   input  logic signed [POS_W-1:0]  center_y,
   input  logic signed [POS_W-1:0]  center_z,
   input  logic [RAD_W-1:0]         radius,
   output geo_word_type             geo_out
);

   // stage 1
   logic                    s1_vld_ff;
   logic signed [L_W-1:0]   s1_l_ff [3];
   logic signed [DIR_W-1:0] s1_d_ff [3];
   logic [RAD_W-1:0]        s1_r_ff;
   // stage 2
   logic                     s2_vld_ff;
   logic signed [PROD_W-1:0] s2_p_ff [3];
   logic [SQ_W-1:0]          s2_sq_ff [3];
   logic [R2_W-1:0]          s2_r2_ff;
   // stage 3
   logic                    s3_vld_ff;
   logic signed [DOT_W-1:0] s3_dot_ff;
   logic [LL_W-1:0]         s3_ll_ff;
   logic [R2_W-1:0]         s3_r2_ff;
   // stage 4
   logic                  s4_vld_ff;
   logic                  s4_neg_ff;
   logic [TCA_W-1:0]      s4_tca_ff;
   logic [TCA2_W-1:0]     s4_tca2_ff;
   logic [LL_W-1:0]       s4_ll_ff;
   logic [R2_W-1:0]       s4_r2_ff;
   // stage 5
   logic                  s5_vld_ff;
   logic                  s5_hit_ff;
   logic [TCA_W-1:0]      s5_tca_ff;
   logic [LIM_W-1:0]      s5_rem_ff;
   logic [LIM_W-1:0]      lim_in;
   logic [TCA_W-1:0]      tca_in;
   logic signed [DOT_W-1:0] dot_in;

   assign dot_in = s2_p_ff[0] + s2_p_ff[1] + s2_p_ff[2];
   assign tca_in = s3_dot_ff[DIR_FRAC +: TCA_W];
   assign lim_in = {1'b0, s4_tca2_ff} + LIM_W'(s4_r2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
      end else if (enable) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_l_ff[0] <= L_W'(center_x) - L_W'(origin_x);
         s1_l_ff[1] <= L_W'(center_y) - L_W'(origin_y);
         s1_l_ff[2] <= L_W'(center_z) - L_W'(origin_z);
         s1_d_ff[0] <= dir_x;
         s1_d_ff[1] <= dir_y;
         s1_d_ff[2] <= dir_z;
         s1_r_ff    <= radius;
         for (int i = 0; i < 3; i++) begin
            s2_p_ff[i]  <= PROD_W'(s1_l_ff[i] * s1_d_ff[i]);
            s2_sq_ff[i] <= SQ_W'(s1_l_ff[i] * s1_l_ff[i]);
         end
         s2_r2_ff   <= R2_W'(s1_r_ff * s1_r_ff);
         s3_dot_ff  <= dot_in;
         s3_ll_ff   <= LL_W'(s2_sq_ff[0]) + LL_W'(s2_sq_ff[1]) + LL_W'(s2_sq_ff[2]);
         s3_r2_ff   <= s2_r2_ff;
         s4_neg_ff  <= s3_dot_ff[DOT_W-1];
         s4_tca_ff  <= tca_in;
         s4_tca2_ff <= TCA2_W'(tca_in * tca_in);
         s4_ll_ff   <= s3_ll_ff;
         s4_r2_ff   <= s3_r2_ff;
         s5_hit_ff  <= !s4_neg_ff && (LIM_W'(s4_ll_ff) <= lim_in);
         s5_tca_ff  <= s4_tca_ff;
         s5_rem_ff  <= lim_in - LIM_W'(s4_ll_ff);
      end
   end

   assign geo_out = '{vld: s5_vld_ff, hit: s5_hit_ff, tca: s5_tca_ff, rem: s5_rem_ff};

endmodule

@@ rtl/rsi_sqrt.sv @@
// Pipelined floor square root, one result bit per stage, plus the final
// distance subtraction. Depends on rsi_pkg.
module rsi_sqrt
   import rsi_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  geo_word_type        geo_in,
   output logic                out_vld,
   output logic                out_hit,
   output logic [DIST_W-1:0]   out_dist
);

   logic             vld_ff [ROOT_W];
   logic             hit_ff [ROOT_W];
   logic [TCA_W-1:0] tca_ff [ROOT_W];
   logic [SQW-1:0]   op_ff  [ROOT_W];
   logic [SQW-1:0]   res_ff [ROOT_W];
   logic             ovld_ff;
   logic             ohit_ff;
   logic [DIST_W-1:0] odist_ff;
   logic [ROOT_W:0]  dist_in;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      localparam logic [SQW-1:0] ONE = SQW'(1) << (2 * (ROOT_W - 1 - k));
      logic             vld_prev;
      logic             hit_prev;
      logic [TCA_W-1:0] tca_prev;
      logic [SQW-1:0]   op_prev;
      logic [SQW-1:0]   res_prev;
      logic [SQW-1:0]   trial;
      logic [SQW-1:0]   op_in;
      logic [SQW-1:0]   res_in;

      if (k == 0) begin : g_head
         assign vld_prev = geo_in.vld;
         assign hit_prev = geo_in.hit;
         assign tca_prev = geo_in.tca;
         assign op_prev  = SQW'(geo_in.rem);
         assign res_prev = '0;
      end else begin : g_body
         assign vld_prev = vld_ff[k-1];
         assign hit_prev = hit_ff[k-1];
         assign tca_prev = tca_ff[k-1];
         assign op_prev  = op_ff[k-1];
         assign res_prev = res_ff[k-1];
      end

      // Classic shift-and-subtract root: take the bit when the trial fits.
      always_comb begin
         trial = res_prev + ONE;
         if (op_prev >= trial) begin
            op_in  = op_prev - trial;
            res_in = (res_prev >> 1) + ONE;
         end else begin
            op_in  = op_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (enable) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            hit_ff[k] <= hit_prev;
            tca_ff[k] <= tca_prev;
            op_ff[k]  <= op_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign dist_in = (ROOT_W+1)'(tca_ff[ROOT_W-1])
                  - (ROOT_W+1)'(res_ff[ROOT_W-1][ROOT_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (enable) begin
         ovld_ff <= vld_ff[ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ohit_ff  <= hit_ff[ROOT_W-1];
         odist_ff <= hit_ff[ROOT_W-1] ? dist_in[DIST_W-1:0] : '0;
      end
   end

   assign out_vld  = ovld_ff;
   assign out_hit  = ohit_ff;
   assign out_dist = odist_ff;

endmodule

@@ rtl/ray_sphere_intersection.sv @@
// Ray-sphere intersection, one test per word, fixed point throughout.
// Pipeline: 5 geometry stages, 38 root stages, 1 output stage. Throughput: one
// word per cycle; the whole pipeline holds while a result waits on rsp_tready.
// Reset (synchronous, active high) clears every valid bit; data is not reset.
module ray_sphere_intersection
   import rsi_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
   // center_x, center_y, center_z, radius, zero pad
   input  logic [IN_W-1:0]   req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // distance, zero pad
   output logic [OUT_W-1:0]  rsp_tdata,
   // hit
   output logic [0:0]        rsp_tuser
);

   logic               enable;
   geo_word_type       geo;
   logic               hit;
   logic [DIST_W-1:0]  distance;

   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   rsi_geometry u_geometry (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_vld   (req_tvalid),
      .origin_x (req_tdata[31:0]),
      .origin_y (req_tdata[63:32]),
      .origin_z (req_tdata[95:64]),
      .dir_x    (req_tdata[113:96]),
      .dir_y    (req_tdata[131:114]),
      .dir_z    (req_tdata[149:132]),
      .center_x (req_tdata[181:150]),
      .center_y (req_tdata[213:182]),
      .center_z (req_tdata[245:214]),
      .radius   (req_tdata[276:246]),
      .geo_out  (geo)
   );

   rsi_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .geo_in   (geo),
      .out_vld  (rsp_tvalid),
      .out_hit  (hit),
      .out_dist (distance)
   );

   assign rsp_tdata = {(OUT_W - DIST_W)'(0), distance};
   assign rsp_tuser = hit;

endmodule

@@ tb/rsi_checker.sv @@
// Checker for the ray-sphere intersection block: watches both channels,
// predicts each result from the accepted request word and compares them.
// Depends on rsi_pkg for the port widths.
module rsi_checker
   import rsi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [OUT_W-1:0] rsp_tdata,
   input  logic [0:0]       rsp_tuser,
   output int               fail_count,
   output int               pending,
   output int               hits_seen,
   output int               misses_seen
);

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] distance;
   } intersection_type;

   intersection_type expected_q[$];

   // Floor square root of a non-negative value, one bit at a time.
   function automatic logic [127:0] floor_root(input logic [127:0] v);
      logic [127:0] res, c;
      res = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         c = res | (128'd1 << b);
         if (c * c <= v)
            res = c;
      end
      return res;
   endfunction

   function automatic intersection_type trace_ray(input logic [IN_W-1:0] w);
      intersection_type res;
      logic signed [127:0] o, c, d, l, dot, ll, tca, r, lim, dist_full;
      dot = 0;
      ll = 0;
      for (int i = 0; i < 3; i++) begin
         o = $signed(w[i*POS_W +: POS_W]);
         d = $signed(w[3*POS_W + i*DIR_W +: DIR_W]);
         c = $signed(w[3*POS_W + 3*DIR_W + i*POS_W +: POS_W]);
         l = c - o;
         dot += l * d;
         ll += l * l;
      end
      r = {97'd0, w[6*POS_W + 3*DIR_W +: RAD_W]};
      res = '0;
      if (dot >= 0) begin
         tca = dot >>> DIR_FRAC;
         lim = tca * tca + r * r;
         if (ll <= lim) begin
            dist_full = tca - $signed(floor_root(lim - ll));
            res.hit = 1'b1;
            res.distance = dist_full[DIST_W-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      intersection_type got, want;
      if (reset) begin
         fail_count <= 0;
         hits_seen <= 0;
         misses_seen <= 0;
         expected_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_q.insert(expected_q.size(), trace_ray(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tuser[0];
            got.distance = rsp_tdata[DIST_W-1:0];
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result word hit=%0b distance=%0d", $time,
                        got.hit, $signed(got.distance));
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got.hit) hits_seen <= hits_seen + 1;
               else misses_seen <= misses_seen + 1;
               if (got.hit !== want.hit) begin
                  $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
                  fail_count <= fail_count + 1;
               end else if (got.distance !== want.distance) begin
                  $display("%0t: distance expected %0d actual %0d", $time,
                           $signed(want.distance), $signed(got.distance));
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

   always_comb pending = expected_q.size();

endmodule

@@ tb/tb_ray_sphere_intersection.sv @@
// Top of the ray-sphere intersection testbench: clock, reset, stimulus and
// verdict. Depends on rsi_pkg, the block itself and rsi_checker.
module tb_ray_sphere_intersection;
   import rsi_pkg::*;

   localparam int ONE = 65536;
   localparam int STALL_LIMIT = 5000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [IN_W-1:0]  req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic [0:0]       rsp_tuser;
   int               fail_count, pending, hits_seen, misses_seen;
   int               idle_pct = 21;
   int               idle_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ray_sphere_intersection DUT (.*);

   rsi_checker u_checker (.*);

   // The watchdog counts cycles with no word moving on either channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= idle_pct);

   // Every argument is a 32-bit value; directions and radius keep their low bits.
   function automatic logic [IN_W-1:0] pack_ray(
      input logic [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz, r);
      logic [IN_W-1:0] w;
      w = '0;
      w[6*POS_W + 3*DIR_W +: RAD_W] = r[RAD_W-1:0];
      w[3*POS_W + 3*DIR_W +: 3*POS_W] = {cz, cy, cx};
      w[3*POS_W +: 3*DIR_W] = {dz[DIR_W-1:0], dy[DIR_W-1:0], dx[DIR_W-1:0]};
      w[0 +: 3*POS_W] = {oz, oy, ox};
      return w;
   endfunction

   task automatic send_ray(input logic [IN_W-1:0] w);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pos(input int span);
      return $signed($urandom_range(2 * span)) - span;
   endfunction

   // Unit-ish direction mostly along x, small cross terms; all random if wild.
   task automatic rand_ray(input bit wild);
      logic [31:0] dx, dy, dz;
      logic [31:0] ox, oy, oz, cx, cy, cz;
      logic [31:0] r;
      int span;
      if (wild) begin
         dx = $urandom; dy = $urandom; dz = $urandom;
         ox = $urandom; oy = $urandom; oz = $urandom;
         cx = $urandom; cy = $urandom; cz = $urandom;
         r = $urandom;
      end else begin
         span = ($urandom_range(3) == 0) ? 32'h7000_0000 : 100 * ONE;
         dx = $signed($urandom_range(2 * ONE)) - ONE;
         dy = $signed($urandom_range(ONE)) - ONE / 2;
         dz = $signed($urandom_range(ONE)) - ONE / 2;
         ox = rand_pos(span); oy = rand_pos(span); oz = rand_pos(span);
         // Centre placed ahead of the origin roughly along the direction.
         cx = ox + dx * $urandom_range(60);
         cy = oy + dy * $urandom_range(60) + rand_pos(4 * ONE);
         cz = oz + dz * $urandom_range(60) + rand_pos(4 * ONE);
         r = $urandom_range(20 * ONE);
      end
      send_ray(pack_ray(ox, oy, oz, dx, dy, dz, cx, cy, cz, r));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Straight hit, origin inside, behind, tangent, zero projection, zero radius.
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 0, 0, 2 * ONE));
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0, 3 * ONE));
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, -10 * ONE, 0, 0, 2 * ONE));
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 10 * ONE, 2 * ONE, 0, 2 * ONE));
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 0, 2 * ONE, 0, 2 * ONE));
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 0, 3 * ONE, 0, 2 * ONE));
      send_ray(pack_ray(0, 0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0));
      send_ray(pack_ray(0, 0, 0, 0, 0, ONE, 0, ONE, 5 * ONE, 0));
      send_ray(pack_ray(0, 0, 0, 0, 0, -ONE, 0, 0, -7 * ONE, ONE));
      // Non-unit directions, including the most negative pattern.
      send_ray(pack_ray(0, 0, 0, 32'h0002_0000, 0, 0, -4 * ONE, 0, 0, ONE));
      send_ray(pack_ray(0, 0, 0, 32'h0001_ffff, 32'h0001_ffff, 32'h0001_ffff,
                        5 * ONE, 5 * ONE, 5 * ONE, 32'h3fff_ffff));
      send_ray(pack_ray(0, 0, 0, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                        -ONE, -ONE, -ONE, 0));
      // Coordinate extremes.
      send_ray(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ONE, ONE, ONE,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_ray(pack_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
      send_ray(pack_ray(32'h8000_0000, 0, 0, ONE, 0, 0, 32'h7fff_ffff, 0, 0, 0));
      send_ray(pack_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 32'h7fff_ffff));
      send_ray(pack_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, -ONE, -ONE, 0,
                        32'h8000_0000, 32'h8000_0000, 0, ONE));
      for (int n = 0; n < 1250; n++) begin
         // A stretch in the middle runs with neither side idling.
         idle_pct = (n >= 500 && n < 700) ? 0 : 21;
         rand_ray($urandom_range(9) == 0);
      end
      req_tvalid <= 1'b0;
      idle_pct = 21;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("Covered %0d hit and %0d miss results, directed corner rays plus random",
               hits_seen, misses_seen);
      $display("rays with and without handshake stalls.");
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
